### design/json_number_lexeme_scanner_assert.svh
// ----------------------------------------------------------------------------
// json_number_lexeme_scanner_assert.svh
// Assertion macros used by the number scanner RTL.
// ----------------------------------------------------------------------------
`ifndef JSON_NUMBER_LEXEME_SCANNER_ASSERT_SVH
`define JSON_NUMBER_LEXEME_SCANNER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define JNLS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define JNLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

### design/jnls_pkg.sv
// ----------------------------------------------------------------------------
// jnls_pkg
// Types, character codes and helpers for the number scanner.
// ----------------------------------------------------------------------------
package jnls_pkg;

    localparam int TOKEN_LENGTH_W = 16;

    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_EXP_LO  = 8'h65;
    localparam logic [7:0] CH_EXP_UP  = 8'h45;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_START      = 4'd1,
        PH_INT_FIRST  = 4'd2,
        PH_INT        = 4'd3,
        PH_FRAC_FIRST = 4'd4,
        PH_FRAC       = 4'd5,
        PH_EXP_SIGN   = 4'd6,
        PH_EXP_FIRST  = 4'd7,
        PH_EXP        = 4'd8
    } scan_phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_flag;
        logic       end_of_data;
    } char_item_t;

    typedef struct packed {
        logic                      is_number;
        logic [TOKEN_LENGTH_W-1:0] token_length;
    } token_item_t;

    // Status handed from the grammar step to the pipeline control.
    typedef struct packed {
        logic        emit;
        logic        ok;
        scan_phase_t phase_next;
    } step_ctrl_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_accepting(input scan_phase_t ph);
        return (ph == PH_INT) || (ph == PH_FRAC) || (ph == PH_EXP);
    endfunction

endpackage

### design/jnls_stream_if.sv
// ----------------------------------------------------------------------------
// jnls_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface jnls_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### design/jnls_step.sv
// ----------------------------------------------------------------------------
// jnls_step
// One grammar step: phase transition, count update and result decision.
// ----------------------------------------------------------------------------
module jnls_step #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                    item_valid,
    input  jnls_pkg::char_item_t    item,
    input  jnls_pkg::scan_phase_t   phase,
    input  logic [COUNT_WIDTH-1:0]  count,
    output jnls_pkg::step_ctrl_t    ctrl,
    output logic [COUNT_WIDTH-1:0]  count_next,
    output logic [COUNT_WIDTH-1:0]  length
);
    import jnls_pkg::*;

    scan_phase_t            eff_phase;
    scan_phase_t            adv_phase;
    logic                   matched;
    logic                   known;
    logic                   active;
    logic                   digit;
    logic [COUNT_WIDTH-1:0] base_count;
    logic [COUNT_WIDTH-1:0] inc_count;

    assign eff_phase  = item.start_flag ? PH_START : phase;
    assign active     = item_valid && (item.start_flag || (phase != PH_IDLE));
    assign digit      = is_digit(item.data_byte);
    assign base_count = item.start_flag ? '0 : count;
    assign inc_count  = (&base_count) ? base_count : base_count + 1'b1;

    // Grammar transition
    always_comb
    begin
        matched   = 1'b0;
        known     = 1'b1;
        adv_phase = PH_IDLE;
        case (eff_phase)
            PH_START:
            begin
                if (item.data_byte == CH_MINUS)
                begin
                    matched = 1'b1; adv_phase = PH_INT_FIRST;
                end
                else if (digit)
                begin
                    matched = 1'b1; adv_phase = PH_INT;
                end
            end
            PH_INT_FIRST, PH_INT:
            begin
                if (digit)
                begin
                    matched = 1'b1; adv_phase = PH_INT;
                end
                else if (eff_phase == PH_INT && item.data_byte == CH_DOT)
                begin
                    matched = 1'b1; adv_phase = PH_FRAC_FIRST;
                end
                else if (eff_phase == PH_INT &&
                         (item.data_byte == CH_EXP_LO || item.data_byte == CH_EXP_UP))
                begin
                    matched = 1'b1; adv_phase = PH_EXP_SIGN;
                end
            end
            PH_FRAC_FIRST, PH_FRAC:
            begin
                if (digit)
                begin
                    matched = 1'b1; adv_phase = PH_FRAC;
                end
                else if (eff_phase == PH_FRAC &&
                         (item.data_byte == CH_EXP_LO || item.data_byte == CH_EXP_UP))
                begin
                    matched = 1'b1; adv_phase = PH_EXP_SIGN;
                end
            end
            PH_EXP_SIGN:
            begin
                if (item.data_byte == CH_PLUS || item.data_byte == CH_MINUS)
                begin
                    matched = 1'b1; adv_phase = PH_EXP_FIRST;
                end
                else if (digit)
                begin
                    matched = 1'b1; adv_phase = PH_EXP;
                end
            end
            PH_EXP_FIRST, PH_EXP:
            begin
                if (digit)
                begin
                    matched = 1'b1; adv_phase = PH_EXP;
                end
            end
            default:
            begin
                known = 1'b0;
            end
        endcase
    end

    // State update and result
    always_comb
    begin
        ctrl.emit       = 1'b0;
        ctrl.ok         = 1'b0;
        ctrl.phase_next = phase;
        count_next      = count;
        length          = '0;
        if (active)
        begin
            ctrl.phase_next = PH_IDLE;
            count_next      = '0;
            if (known && !matched)
            begin
                // byte not counted; a complete number so far is a success
                ctrl.emit = 1'b1;
                ctrl.ok   = is_accepting(eff_phase);
                length    = ctrl.ok ? base_count : '0;
            end
            else if (known && item.end_of_data)
            begin
                ctrl.emit = 1'b1;
                ctrl.ok   = is_accepting(adv_phase);
                length    = ctrl.ok ? inc_count : '0;
            end
            else if (known)
            begin
                ctrl.phase_next = adv_phase;
                count_next      = inc_count;
            end
        end
    end

endmodule

### design/json_number_lexeme_scanner.sv
// ----------------------------------------------------------------------------
// json_number_lexeme_scanner: byte-wide JSON number lexeme scanner.
// Results are registered. Throughput: one byte per cycle unless a held result
// stalls, set by the single grammar step between the input register and the
// result register. Reset: scan idle, count zero.
// ----------------------------------------------------------------------------
module json_number_lexeme_scanner #(
    parameter int LENGTH_WIDTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    jnls_stream_if.sink       chars,
    jnls_stream_if.source     tokens
);
    import jnls_pkg::*;

`include "json_number_lexeme_scanner_assert.svh"

    // Count saturates at the lesser of the parameter width and the port width.
    localparam int COUNT_WIDTH = (LENGTH_WIDTH < TOKEN_LENGTH_W) ? LENGTH_WIDTH
                                                                 : TOKEN_LENGTH_W;

    // Input register: holds one byte ahead of the grammar step.
    logic                   in_valid_reg, in_valid_next;
    char_item_t             in_item_reg;

    // Scan state, updated when the held byte moves on.
    scan_phase_t            phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;

    // Result register.
    logic                   out_valid_reg, out_valid_next;
    token_item_t            out_item_reg, out_item_next;

    step_ctrl_t             step_ctrl;
    logic [COUNT_WIDTH-1:0] step_count;
    logic [COUNT_WIDTH-1:0] step_length;
    logic                   advance;
    logic                   take;

    // The held byte may move on whenever the result slot is empty or being
    // drained this cycle; bytes that give no result wait on it as well.
    assign advance      = !out_valid_reg || tokens.ready;
    assign chars.ready  = !in_valid_reg || advance;
    assign take         = chars.valid && chars.ready;

    assign tokens.valid   = out_valid_reg;
    assign tokens.payload = out_item_reg;

    jnls_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .item_valid (in_valid_reg),
        .item       (in_item_reg),
        .phase      (phase_reg),
        .count      (count_reg),
        .ctrl       (step_ctrl),
        .count_next (step_count),
        .length     (step_length)
    );

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        phase_next     = phase_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (advance)
        begin
            in_valid_next  = take;
            out_valid_next = in_valid_reg && step_ctrl.emit;
            if (in_valid_reg)
            begin
                phase_next = step_ctrl.phase_next;
                count_next = step_count;
            end
            if (in_valid_reg && step_ctrl.emit)
            begin
                out_item_next.is_number    = step_ctrl.ok;
                out_item_next.token_length = TOKEN_LENGTH_W'(step_length);
            end
        end
        else if (take)
        begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_item_reg <= chars.payload;
        end
        out_item_reg <= out_item_next;
    end

    // Checks
    `JNLS_ASSERT_NOW(a_fail_len_zero, clk, rst_n,
        out_valid_reg && !out_item_reg.is_number, out_item_reg.token_length == '0,
        "failure result with nonzero length")
    `JNLS_ASSERT_NOW(a_ok_len_nonzero, clk, rst_n,
        out_valid_reg && out_item_reg.is_number, out_item_reg.token_length != '0,
        "number result with zero length")
    `JNLS_ASSERT_NOW(a_idle_count_zero, clk, rst_n,
        phase_reg == PH_IDLE, count_reg == '0,
        "idle scan with residual count")
    `JNLS_ASSERT_NEXT(a_emit_ends_scan, clk, rst_n,
        in_valid_reg && advance && step_ctrl.emit, out_valid_reg && phase_reg == PH_IDLE,
        "result issued without ending the scan")

endmodule
